// ===== rtl/core/bsba_pkg.sv =====
// Shared constants and small types for the binned slab buffer allocator.
// No dependencies; imported by the allocator top level.
package bsba_pkg;

    // Pool geometry.
    localparam int BLKS   = 16;
    localparam int BLK_W  = 4;
    localparam int BUFS   = 64;
    localparam int SLOT_W = 6;
    localparam int BINS   = 16;
    localparam int BIN_W  = 5;
    localparam int CNT_W  = 7;

    // Null markers for block links and free-list heads.
    localparam logic [BIN_W-1:0] NULL_BLK  = 5'd16;
    localparam logic [CNT_W-1:0] NULL_SLOT = 7'd64;

    // Configuration register indexes.
    localparam logic CFG_BUFS = 1'b0;
    localparam logic CFG_BINS = 1'b1;

    // Request kinds.
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef logic [BIN_W-1:0] link_t;

endpackage

// ===== rtl/core/bsba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the allocator's slot tables.
module bsba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ===== rtl/core/binned_slab_buffer_allocator.sv =====
// Top level of the binned slab buffer allocator.
// Depends on bsba_pkg and bsba_ram.
//
// Usage: each word on the s_axis channel is one request. tuser[0] selects
// allocate (0) or free (1); for a free, tdata carries the block and slot.
// Each request yields exactly one result word on m_axis: status, the given
// block and slot, and whether a free released its whole block.
// Configuration words (index 0 slots per block, index 1 bin count) are taken
// at any time and empty the whole pool; write them only while idle.
// A request is worked through by a small sequencer around one shared
// multiply / shift-subtract divider that computes the occupancy bin.
// Steps: an allocate from a live block finds it, reads and updates its slot
// tables, multiplies and runs the five-step bin divider, compares, and when the
// block moves bin unlinks and appends it; a fresh-block claim skips the read,
// update and unlink; a free checks, updates and goes on as an allocate, or only
// unlinks a block it releases; failed allocates and rejected frees go to output.
// One request is in flight at a time; s_axis_tready is high only when idle,
// which is from the cycle after the result register loads.
// The result register lets a new request start while a result waits, but a
// second result waits in the sequencer until m_axis_tready takes the first.
// Reset empties the pool (no live blocks, all bins empty) and restores
// 64 slots per block and 8 bins. No clearing pass is needed: a block's
// in-use row is rewritten whenever the block is claimed.
module binned_slab_buffer_allocator (
    input  logic        clk,
    input  logic        rst_n,
    // Request channel.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // free_block [3:0], free_slot [9:4], zero [15:10]
    input  logic [0:0]  s_axis_tuser,  // action [0]
    // Result channel.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // status [0], given_block [4:1], given_slot [10:5],
                                       // block_released [11], zero [15:12]
    // Configuration channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    import bsba_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_AFIND = 4'd1;
    localparam logic [3:0] S_AREAD = 4'd2;
    localparam logic [3:0] S_AUPD  = 4'd3;
    localparam logic [3:0] S_FCHK  = 4'd4;
    localparam logic [3:0] S_FUPD  = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_CMP   = 4'd8;
    localparam logic [3:0] S_REM   = 4'd9;
    localparam logic [3:0] S_APP   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0]        state_reg;
    logic [6:0]        bufs_cfg_reg;
    logic [4:0]        bins_cfg_reg;
    logic [BLKS-1:0]   live_reg;
    link_t             head_reg [BINS+1];
    link_t             tail_reg [BINS+1];

    logic [CNT_W-1:0]  used_reg    [BLKS];
    logic [CNT_W-1:0]  touched_reg [BLKS];
    logic [BIN_W-1:0]  bin_reg     [BLKS];
    logic [CNT_W-1:0]  fhead_reg   [BLKS];
    link_t             prev_reg    [BLKS];
    link_t             next_reg    [BLKS];

    logic [BLK_W-1:0]  k_reg;
    logic [SLOT_W-1:0] s_reg;
    logic              act_reg;
    logic              claim_reg;
    logic              app_reg;
    logic [11:0]       prod_reg;
    logic [4:0]        quo_reg;
    logic [2:0]        cnt_reg;
    logic [BIN_W-1:0]  nb_reg;

    logic              res_status_reg;
    logic [BLK_W-1:0]  res_block_reg;
    logic [SLOT_W-1:0] res_slot_reg;
    logic              res_rel_reg;
    logic              out_valid_reg;
    logic [15:0]       out_data_reg;

    // Effective configuration.
    logic [6:0]        bufs_eff;
    logic [4:0]        bins_eff;
    logic [4:0]        bins_lim;

    always_comb
    begin
        if (bufs_cfg_reg == 7'd0)
        begin
            bufs_eff = 7'd1;
        end
        else if (bufs_cfg_reg > 7'(BUFS))
        begin
            bufs_eff = 7'(BUFS);
        end
        else
        begin
            bufs_eff = bufs_cfg_reg;
        end
        bins_lim = (bins_cfg_reg == 5'd0) ? 5'd1 : bins_cfg_reg;
        if (bins_lim > 5'(BINS))
        begin
            bins_lim = 5'(BINS);
        end
        bins_eff = ({2'b00, bins_lim} > bufs_eff) ? bufs_eff[4:0] : bins_lim;
    end

    // Highest non-empty bin below the full bin, and lowest unused block.
    logic              found;
    logic [BIN_W-1:0]  fbin;
    logic              any_free;
    logic [BLK_W-1:0]  free_idx;

    always_comb
    begin
        found    = 1'b0;
        fbin     = '0;
        any_free = 1'b0;
        free_idx = '0;
        for (int b = 0; b < BINS; b++)
        begin
            if (tail_reg[b] != NULL_BLK && BIN_W'(b) < bins_eff)
            begin
                found = 1'b1;
                fbin  = BIN_W'(b);
            end
        end
        for (int i = BLKS - 1; i >= 0; i--)
        begin
            if (!live_reg[i])
            begin
                any_free = 1'b1;
                free_idx = BLK_W'(i);
            end
        end
    end

    // Slot tables: free-list links per slot and in-use bits per block row.
    logic              nf_we;
    logic [CNT_W-1:0]  nf_rdata;
    logic              row_we;
    logic [BLK_W-1:0]  row_waddr;
    logic [BUFS-1:0]   row_wdata;
    logic [BUFS-1:0]   row_rdata;

    logic [CNT_W-1:0]  fh_k;
    logic [SLOT_W-1:0] alloc_slot;
    logic [CNT_W-1:0]  used_dec;
    logic              rel_cond;
    logic              free_ok;
    logic [11:0]       div_sh;

    assign fh_k       = fhead_reg[k_reg];
    assign alloc_slot = fh_k[SLOT_W] ? touched_reg[k_reg][SLOT_W-1:0] : fh_k[SLOT_W-1:0];
    assign used_dec   = used_reg[k_reg] - 7'd1;
    assign rel_cond   = (used_dec == 7'd0) && (head_reg[0] != NULL_BLK) &&
                        ((head_reg[0] != {1'b0, k_reg}) || (tail_reg[0] != {1'b0, k_reg}));
    assign free_ok    = live_reg[k_reg] && ({1'b0, s_reg} < bufs_eff) &&
                        ({1'b0, s_reg} < touched_reg[k_reg]);
    assign div_sh     = 12'(bufs_eff) << cnt_reg;

    assign nf_we = (state_reg == S_FUPD) && row_rdata[s_reg] && !rel_cond;

    always_comb
    begin
        row_we    = 1'b0;
        row_waddr = k_reg;
        row_wdata = row_rdata;
        if (state_reg == S_AFIND && !found && any_free)
        begin
            row_we    = 1'b1;
            row_waddr = free_idx;
            row_wdata = BUFS'(1);
        end
        else if (state_reg == S_AUPD)
        begin
            row_we    = 1'b1;
            row_wdata = row_rdata | (BUFS'(1) << alloc_slot);
        end
        else if (state_reg == S_FUPD && row_rdata[s_reg])
        begin
            row_we    = 1'b1;
            row_wdata = row_rdata & ~(BUFS'(1) << s_reg);
        end
    end

    bsba_ram #(.WIDTH(CNT_W), .DEPTH(BLKS * BUFS)) u_next_ram (
        .clk   (clk),
        .we    (nf_we),
        .waddr ({k_reg, s_reg}),
        .wdata (fh_k),
        .raddr ({k_reg, fh_k[SLOT_W-1:0]}),
        .rdata (nf_rdata)
    );

    bsba_ram #(.WIDTH(BUFS), .DEPTH(BLKS)) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .raddr (k_reg),
        .rdata (row_rdata)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    logic in_acc;
    logic cfg_acc;
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign cfg_acc = cfg_valid && cfg_ready;

    // Sequencer, configuration, live bits and bin list ends.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bufs_cfg_reg  <= 7'd64;
            bins_cfg_reg  <= 5'd8;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int b = 0; b <= BINS; b++)
            begin
                head_reg[b] <= NULL_BLK;
                tail_reg[b] <= NULL_BLK;
            end
        end
        else
        begin
            // The result word is valid from its load until the receiver takes it.
            if (state_reg == S_OUT && (!out_valid_reg || m_axis_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tvalid && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        state_reg <= (s_axis_tuser[0] == ACT_FREE) ? S_FCHK : S_AFIND;
                    end
                end
                S_AFIND:
                begin
                    if (found)
                    begin
                        state_reg <= S_AREAD;
                    end
                    else if (any_free)
                    begin
                        live_reg[free_idx] <= 1'b1;
                        state_reg          <= S_MUL;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_AREAD: state_reg <= S_AUPD;
                S_AUPD:  state_reg <= S_MUL;
                S_FCHK:  state_reg <= free_ok ? S_FUPD : S_OUT;
                S_FUPD:
                begin
                    if (!row_rdata[s_reg])
                    begin
                        state_reg <= S_OUT;
                    end
                    else if (rel_cond)
                    begin
                        live_reg[k_reg] <= 1'b0;
                        state_reg       <= S_REM;
                    end
                    else
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: state_reg <= S_DIV;
                S_DIV:
                begin
                    if (cnt_reg == 3'd0)
                    begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    if (claim_reg)
                    begin
                        state_reg <= S_APP;
                    end
                    else if (((quo_reg > bins_eff) ? bins_eff : quo_reg) != bin_reg[k_reg])
                    begin
                        state_reg <= S_REM;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_REM:
                begin
                    if (prev_reg[k_reg] == NULL_BLK)
                    begin
                        head_reg[bin_reg[k_reg]] <= next_reg[k_reg];
                    end
                    if (next_reg[k_reg] == NULL_BLK)
                    begin
                        tail_reg[bin_reg[k_reg]] <= prev_reg[k_reg];
                    end
                    state_reg <= app_reg ? S_APP : S_OUT;
                end
                S_APP:
                begin
                    if (tail_reg[nb_reg] == NULL_BLK)
                    begin
                        head_reg[nb_reg] <= {1'b0, k_reg};
                    end
                    tail_reg[nb_reg] <= {1'b0, k_reg};
                    state_reg        <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            // A configuration write empties the pool.
            if (cfg_acc)
            begin
                if (cfg_index[0] == CFG_BUFS)
                begin
                    bufs_cfg_reg <= cfg_data;
                end
                else
                begin
                    bins_cfg_reg <= cfg_data[4:0];
                end
                live_reg <= '0;
                for (int b = 0; b <= BINS; b++)
                begin
                    head_reg[b] <= NULL_BLK;
                    tail_reg[b] <= NULL_BLK;
                end
            end
        end
    end

    // Per-block records, the shared divider and the result word.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    act_reg        <= s_axis_tuser[0];
                    k_reg          <= s_axis_tdata[3:0];
                    s_reg          <= s_axis_tdata[9:4];
                    claim_reg      <= 1'b0;
                    res_status_reg <= 1'b0;
                    res_block_reg  <= '0;
                    res_slot_reg   <= '0;
                    res_rel_reg    <= 1'b0;
                end
            end
            S_AFIND:
            begin
                if (found)
                begin
                    k_reg <= tail_reg[fbin][BLK_W-1:0];
                end
                else if (any_free)
                begin
                    k_reg                 <= free_idx;
                    claim_reg             <= 1'b1;
                    used_reg[free_idx]    <= 7'd1;
                    touched_reg[free_idx] <= 7'd1;
                    fhead_reg[free_idx]   <= NULL_SLOT;
                    res_block_reg         <= free_idx;
                end
                else
                begin
                    res_status_reg <= 1'b1;
                end
            end
            S_AREAD:
            begin
            end
            S_AUPD:
            begin
                if (fh_k[SLOT_W])
                begin
                    touched_reg[k_reg] <= touched_reg[k_reg] + 7'd1;
                end
                else
                begin
                    fhead_reg[k_reg] <= nf_rdata;
                end
                used_reg[k_reg] <= used_reg[k_reg] + 7'd1;
                res_block_reg   <= k_reg;
                res_slot_reg    <= alloc_slot;
            end
            S_FCHK:
            begin
            end
            S_FUPD:
            begin
                if (row_rdata[s_reg])
                begin
                    used_reg[k_reg] <= used_dec;
                    app_reg         <= 1'b0;
                    if (rel_cond)
                    begin
                        res_rel_reg <= 1'b1;
                    end
                    else
                    begin
                        fhead_reg[k_reg] <= {1'b0, s_reg};
                    end
                end
            end
            S_MUL:
            begin
                prod_reg <= 12'(used_reg[k_reg] * bins_eff);
                quo_reg  <= '0;
                cnt_reg  <= 3'd4;
            end
            S_DIV:
            begin
                if (prod_reg >= div_sh)
                begin
                    prod_reg         <= prod_reg - div_sh;
                    quo_reg[cnt_reg] <= 1'b1;
                end
                if (cnt_reg != 3'd0)
                begin
                    cnt_reg <= cnt_reg - 3'd1;
                end
            end
            S_CMP:
            begin
                nb_reg  <= (quo_reg > bins_eff) ? bins_eff : quo_reg;
                app_reg <= 1'b1;
            end
            S_REM:
            begin
                if (prev_reg[k_reg] != NULL_BLK)
                begin
                    next_reg[prev_reg[k_reg][BLK_W-1:0]] <= next_reg[k_reg];
                end
                if (next_reg[k_reg] != NULL_BLK)
                begin
                    prev_reg[next_reg[k_reg][BLK_W-1:0]] <= prev_reg[k_reg];
                end
            end
            S_APP:
            begin
                bin_reg[k_reg]  <= nb_reg;
                prev_reg[k_reg] <= tail_reg[nb_reg];
                next_reg[k_reg] <= NULL_BLK;
                if (tail_reg[nb_reg] != NULL_BLK)
                begin
                    next_reg[tail_reg[nb_reg][BLK_W-1:0]] <= {1'b0, k_reg};
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_reg <= {4'b0000, res_rel_reg, res_slot_reg,
                                     res_block_reg, res_status_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    // A failed allocate never reports a release or a buffer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && res_status_reg) |-> (!res_rel_reg && res_block_reg == '0))
        else $error("failed allocate carries buffer or release");

    // A release only comes from a free request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && res_rel_reg) |-> (act_reg == ACT_FREE))
        else $error("release reported on allocate");

    // The divider runs down to the compare step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg != 3'd0 && !cfg_acc) |=> (state_reg == S_DIV))
        else $error("divider left early");

    // Bin 0 head and tail are empty together.
    assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg[0] == NULL_BLK) == (tail_reg[0] == NULL_BLK))
        else $error("bin 0 list ends disagree");

endmodule

// ===== tb/sv/binned_slab_buffer_allocator_chk.sv =====
`timescale 1ns / 1ps
// Checker for the binned slab buffer allocator: watches the request, result and
// configuration channels, predicts each result word and compares. Uses bsba_pkg.
module binned_slab_buffer_allocator_chk (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic [0:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    output int          errors,
    output int          pending
);

    import bsba_pkg::*;

    typedef struct packed {
        logic             status;
        logic [BLK_W-1:0] blk;
        logic [SLOT_W-1:0] slot;
        logic             released;
    } grant_t;

    // Shadow of the pool.
    int     slots_cfg;
    int     bins_setting;
    bit     live [BLKS];
    int     used [BLKS];
    int     touched [BLKS];
    int     bin_no [BLKS];
    int     free_head [BLKS];
    int     nxt_free [BLKS*BUFS];
    bit     busy [BLKS*BUFS];
    int     prv [BLKS];
    int     nxt [BLKS];
    int     head [BINS+1];
    int     tail [BINS+1];
    grant_t grants_due [$];

    function automatic int slots_eff();
        int b;
        b = slots_cfg;
        if (b == 0) b = 1;
        if (b > BUFS) b = BUFS;
        return b;
    endfunction

    function automatic int bins_eff();
        int n;
        n = bins_setting;
        if (n == 0) n = 1;
        if (n > BINS) n = BINS;
        if (n > slots_eff()) n = slots_eff();
        return n;
    endfunction

    function automatic int occupancy_bin(int u);
        int r;
        r = u * bins_eff() / slots_eff();
        return (r > bins_eff()) ? bins_eff() : r;
    endfunction

    task automatic empty_pool();
        for (int i = 0; i < BLKS; i++)
        begin
            live[i] = 0; used[i] = 0; touched[i] = 0; bin_no[i] = 0;
            free_head[i] = 0; prv[i] = 0; nxt[i] = 0;
        end
        for (int i = 0; i < BLKS*BUFS; i++)
        begin
            nxt_free[i] = 0; busy[i] = 0;
        end
        for (int i = 0; i <= BINS; i++)
        begin
            head[i] = BLKS; tail[i] = BLKS;
        end
    endtask

    task automatic unlink(int k);
        int b, p, n;
        b = bin_no[k]; p = prv[k]; n = nxt[k];
        if (p < BLKS) nxt[p] = n; else head[b] = n;
        if (n < BLKS) prv[n] = p; else tail[b] = p;
    endtask

    task automatic link_tail(int b, int k);
        int t;
        t = tail[b];
        bin_no[k] = b; prv[k] = t; nxt[k] = BLKS;
        if (t < BLKS) nxt[t] = k; else head[b] = k;
        tail[b] = k;
    endtask

    task automatic move_bin(int k);
        int nb;
        nb = occupancy_bin(used[k]);
        if (nb != bin_no[k])
        begin
            unlink(k);
            link_tail(nb, k);
        end
    endtask

    // Work out the result word of one request and update the shadow pool.
    task automatic predict_grant(logic act, int fb, int fs, output grant_t g);
        int k, b, s, i;
        g = '0;
        if (act == ACT_ALLOC)
        begin
            k = BLKS;
            b = bins_eff();
            while (b > 0)
            begin
                b--;
                if (tail[b] < BLKS)
                begin
                    k = tail[b];
                    break;
                end
            end
            if (k < BLKS)
            begin
                if (free_head[k] < BUFS)
                begin
                    s = free_head[k];
                    free_head[k] = nxt_free[k*BUFS + s];
                end
                else
                begin
                    s = touched[k];
                    if (s >= slots_eff()) s = slots_eff() - 1;
                    touched[k] = s + 1;
                end
                busy[k*BUFS + s] = 1;
                used[k]++;
                move_bin(k);
                g.blk = BLK_W'(k); g.slot = SLOT_W'(s);
            end
            else
            begin
                for (i = 0; i < BLKS; i++)
                    if (!live[i]) break;
                if (i < BLKS)
                begin
                    live[i] = 1; used[i] = 1; touched[i] = 1;
                    free_head[i] = BUFS;
                    busy[i*BUFS] = 1;
                    link_tail(occupancy_bin(1), i);
                    g.blk = BLK_W'(i);
                end
                else
                    g.status = 1'b1;
            end
        end
        else if (live[fb] && fs < slots_eff() && fs < touched[fb] && busy[fb*BUFS + fs])
        begin
            busy[fb*BUFS + fs] = 0;
            used[fb]--;
            // An emptied block goes back only when bin 0 keeps another block.
            if (used[fb] == 0 && head[0] < BLKS && (head[0] != fb || tail[0] != fb))
            begin
                unlink(fb);
                live[fb] = 0;
                g.released = 1'b1;
            end
            else
            begin
                nxt_free[fb*BUFS + fs] = free_head[fb];
                free_head[fb] = fs;
                move_bin(fb);
            end
        end
    endtask

    // Predict on request words, compare on result words, follow register writes.
    always @(posedge clk or negedge rst_n)
    begin
        grant_t g, seen;
        if (!rst_n)
        begin
            slots_cfg = 64;
            bins_setting = 8;
            empty_pool();
            grants_due.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_BUFS) slots_cfg = int'(cfg_data);
                else bins_setting = int'(cfg_data[4:0]);
                empty_pool();
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_grant(s_axis_tuser[0], int'(s_axis_tdata[3:0]),
                              int'(s_axis_tdata[9:4]), g);
                grants_due.push_back(g);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen = {m_axis_tdata[0], m_axis_tdata[4:1], m_axis_tdata[10:5],
                        m_axis_tdata[11]};
                if (grants_due.size() == 0)
                begin
                    $error("result word with nothing expected: %h", m_axis_tdata);
                    errors++;
                end
                else
                begin
                    g = grants_due.pop_front();
                    if (seen.status !== g.status)
                    begin
                        $error("status: expected %0d, got %0d", g.status, seen.status);
                        errors++;
                    end
                    if (seen.blk !== g.blk)
                    begin
                        $error("given_block: expected %0d, got %0d", g.blk, seen.blk);
                        errors++;
                    end
                    if (seen.slot !== g.slot)
                    begin
                        $error("given_slot: expected %0d, got %0d", g.slot, seen.slot);
                        errors++;
                    end
                    if (seen.released !== g.released)
                    begin
                        $error("block_released: expected %0d, got %0d",
                               g.released, seen.released);
                        errors++;
                    end
                    if (m_axis_tdata[15:12] !== 4'd0)
                    begin
                        $error("pad bits: expected 0, got %h", m_axis_tdata[15:12]);
                        errors++;
                    end
                end
            end
            pending = grants_due.size();
        end
    end

endmodule

// ===== tb/sv/binned_slab_buffer_allocator_tb.sv =====
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, request and register stimulus,
// result back-pressure and the verdict. Depends on bsba_pkg and the checker.
module binned_slab_buffer_allocator_tb;
    import bsba_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;  // free_block [3:0], free_slot [9:4], zero [15:10]
    logic [0:0]  s_axis_tuser = '0;  // action [0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [15:0] m_axis_tdata;       // status [0], given_block [4:1], given_slot [10:5],
                                     // block_released [11], zero [15:12]
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [6:0]  cfg_data = '0;
    int          errors;
    int          pending;

    bit          burst;        // no gaps on either side while set
    bit          long_hold;    // receiver holds off once for a long stretch
    logic        kinds_sent [$];
    int          held_bufs [$];  // {block, slot} of buffers handed out and not freed

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    binned_slab_buffer_allocator dut (.*);

    binned_slab_buffer_allocator_chk chk (.*);

    // Track which buffers are out so frees can name real ones.
    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready) kinds_sent.push_back(s_axis_tuser[0]);
        if (m_axis_tvalid && m_axis_tready && kinds_sent.size() > 0)
            if (kinds_sent.pop_front() == ACT_ALLOC && !m_axis_tdata[0])
                held_bufs.push_back(int'({m_axis_tdata[4:1], m_axis_tdata[10:5]}));
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        int w;
        @(posedge rst_n);
        forever
        begin
            w = burst ? 0 : $urandom_range(0, 5);
            if (long_hold)
            begin
                long_hold = 0;
                w = 400;
            end
            if (w > 0)
            begin
                m_axis_tready <= 0;
                repeat (w) @(posedge clk);
            end
            m_axis_tready <= 1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
        end
    end

    task automatic send_req(logic act, int blk, int slot);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {6'd0, slot[5:0], blk[3:0]};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [6:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    // Stop offering requests and let the block drain completely.
    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic random_run(int n, bit with_hold);
        int r, i, b;
        for (int j = 0; j < n; j++)
        begin
            if (j % 40 == 0) burst = ($urandom_range(0, 3) == 0);
            if (with_hold && j == n / 2) long_hold = 1;
            r = $urandom_range(0, 99);
            if (r < 55)
                send_req(ACT_ALLOC, $urandom_range(0, 15), $urandom_range(0, 63));
            else if (r < 88 && held_bufs.size() > 0)
            begin
                i = $urandom_range(0, held_bufs.size() - 1);
                b = held_bufs[i];
                held_bufs.delete(i);
                send_req(ACT_FREE, int'(b[9:6]), int'(b[5:0]));
            end
            else
                send_req(ACT_FREE, $urandom_range(0, 15), $urandom_range(0, 63));
        end
    endtask

    initial
    begin
        int slots_tab [7] = '{64, 1, 4, 127, 0, 7, 64};
        int bins_tab [7]  = '{8, 1, 16, 31, 0, 3, 16};
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: reset settings, bad frees, double free, emptied lone block.
        send_req(ACT_ALLOC, 15, 63);
        send_req(ACT_FREE, 9, 0);
        send_req(ACT_ALLOC, 0, 0);
        send_req(ACT_FREE, 0, 63);
        send_req(ACT_FREE, 0, 5);
        send_req(ACT_FREE, 0, 0);
        send_req(ACT_FREE, 0, 0);
        send_req(ACT_FREE, 0, 1);
        send_req(ACT_ALLOC, 0, 0);
        send_req(ACT_ALLOC, 0, 0);
        drain();
        held_bufs.delete();

        for (int p = 0; p < 7; p++)
        begin
            if (p > 0)
            begin
                write_reg(CFG_BUFS, 7'(slots_tab[p]));
                write_reg(CFG_BINS, 7'(bins_tab[p]));
                held_bufs.delete();
            end
            // One slot per block: every allocate claims a block until none is left.
            if (p == 1)
                for (int j = 0; j < 17; j++) send_req(ACT_ALLOC, 0, 0);
            random_run(240, p == 2 || p == 5);
            drain();
        end

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
